### rtl/core/rnmt_pkg.sv
// rnmt_pkg: shared constants, opcodes and types for the relu neuron mac/train unit
`timescale 1ns / 1ps
package rnmt_pkg;

  localparam int MAX_INPUTS = 64;
  localparam int IDX_W      = $clog2(MAX_INPUTS);
  localparam int LEN_W      = 7;
  localparam int RATE_W     = 31;
  localparam int VAL_W      = 32;
  localparam int FRAC_W     = 16;
  localparam int PROD_W     = 2 * VAL_W;
  localparam int SHP_W      = PROD_W - FRAC_W;
  localparam int ACC_W      = SHP_W + IDX_W;
  localparam int OP_W       = 3;
  localparam int IN_DATA_W  = ((IDX_W + VAL_W + 7) / 8) * 8;
  localparam int FIFO_DEPTH = 8;
  localparam int FIFO_AW    = $clog2(FIFO_DEPTH);

  localparam logic [OP_W-1:0] OP_WRITE = 3'd0;
  localparam logic [OP_W-1:0] OP_SUB   = 3'd1;
  localparam logic [OP_W-1:0] OP_ELEM  = 3'd2;
  localparam logic [OP_W-1:0] OP_DELTA = 3'd3;
  localparam logic [OP_W-1:0] OP_BIAS  = 3'd4;

  localparam logic KIND_ACT   = 1'b0;
  localparam logic KIND_DELTA = 1'b1;

  localparam logic CFG_ACTIVE = 1'b0;
  localparam logic CFG_RATE   = 1'b1;

  localparam logic [LEN_W-1:0]  ACTIVE_RESET = 7'd64;
  localparam logic [RATE_W-1:0] RATE_RESET   = 31'd65536;

  typedef struct packed {
    logic              kind;
    logic [VAL_W-1:0]  value;
  } result_t;

endpackage

### rtl/core/rnmt_ram.sv
// rnmt_ram: generic single-port-write ram with registered read
`timescale 1ns / 1ps
module rnmt_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // read returns the old contents on a same-address write
  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

endmodule

### rtl/core/rnmt_fifo.sv
// rnmt_fifo: small result queue in front of the output stream
`timescale 1ns / 1ps
module rnmt_fifo (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      push,
  input  rnmt_pkg::result_t         push_data,
  output logic                      out_valid,
  input  logic                      out_ready,
  output rnmt_pkg::result_t         out_data,
  output logic [rnmt_pkg::FIFO_AW:0] level
);

  rnmt_pkg::result_t              entries [rnmt_pkg::FIFO_DEPTH];
  logic [rnmt_pkg::FIFO_AW-1:0]   wr_ptr;
  logic [rnmt_pkg::FIFO_AW-1:0]   rd_ptr;
  logic                           pop;

  assign out_valid = (level != '0);
  assign out_data  = entries[rd_ptr];
  assign pop       = out_valid && out_ready;

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      level  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      case ({push, pop})
        2'b10:   level <= level + 1'b1;
        2'b01:   level <= level - 1'b1;
        default: level <= level;
      endcase
    end
  end

endmodule

### rtl/core/relu_neuron_mac_train_unit.sv
// relu_neuron_mac_train_unit: relu neuron with weight ram, mac pipeline and bias update
//
//  channel   direction  handshake                      payload
//  s_axis    in         s_axis_tvalid/s_axis_tready    tuser opcode, tdata index+operand
//  m_axis    out        m_axis_tvalid/m_axis_tready    tuser kind, tdata result value
//  cfg       in         cfg_valid/cfg_ready            cfg_index, cfg_data
//
//  one item per cycle while s_axis_tready is high; a result passes the stage 1, 2, 3 registers
//  to the queue (weight ram read, 32x32 multiply, accumulate, bias add and saturate)
//  weight ram read-modify-write is forwarded, so no item waits on another
//  reset clears control, bias, activation and the running sum; weights are undefined
//  s_axis_tready drops only when the 8-entry result queue plus results in flight is full
`timescale 1ns / 1ps
module relu_neuron_mac_train_unit (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               s_axis_tvalid,
  output logic                               s_axis_tready,
  input  logic [rnmt_pkg::IN_DATA_W-1:0]     s_axis_tdata,  // weight_index, operand_value
  input  logic [rnmt_pkg::OP_W-1:0]          s_axis_tuser,  // opcode
  output logic                               m_axis_tvalid,
  input  logic                               m_axis_tready,
  output logic [rnmt_pkg::VAL_W-1:0]         m_axis_tdata,  // result_value
  output logic                               m_axis_tuser,  // result_kind
  input  logic                               cfg_valid,
  output logic                               cfg_ready,
  input  logic                               cfg_index,
  input  logic [rnmt_pkg::RATE_W-1:0]        cfg_data
);

  function automatic logic signed [rnmt_pkg::VAL_W-1:0] sat32(
    input logic signed [rnmt_pkg::ACC_W:0] x
  );
    logic signed [rnmt_pkg::ACC_W:0] hi;
    logic signed [rnmt_pkg::ACC_W:0] lo;
    hi = (rnmt_pkg::ACC_W+1)'(32'sh7FFF_FFFF);
    lo = (rnmt_pkg::ACC_W+1)'(32'sh8000_0000);
    if (x > hi) begin
      sat32 = 32'sh7FFF_FFFF;
    end else if (x < lo) begin
      sat32 = 32'sh8000_0000;
    end else begin
      sat32 = x[rnmt_pkg::VAL_W-1:0];
    end
  endfunction

  // configuration
  logic [rnmt_pkg::LEN_W-1:0]  active_inputs;
  logic [rnmt_pkg::RATE_W-1:0] learning_rate;
  logic [rnmt_pkg::LEN_W-1:0]  sum_len;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      active_inputs <= rnmt_pkg::ACTIVE_RESET;
      learning_rate <= rnmt_pkg::RATE_RESET;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        rnmt_pkg::CFG_ACTIVE: active_inputs <= cfg_data[rnmt_pkg::LEN_W-1:0];
        rnmt_pkg::CFG_RATE:   learning_rate <= cfg_data;
        default: ;
      endcase
    end
  end

  always_comb begin
    if (active_inputs == '0) begin
      sum_len = rnmt_pkg::LEN_W'(1);
    end else if (active_inputs > rnmt_pkg::LEN_W'(rnmt_pkg::MAX_INPUTS)) begin
      sum_len = rnmt_pkg::LEN_W'(rnmt_pkg::MAX_INPUTS);
    end else begin
      sum_len = active_inputs;
    end
  end

  // stage 0: transfer, element counter, ram read address
  logic                             accept;
  logic [rnmt_pkg::OP_W-1:0]        in_op;
  logic [rnmt_pkg::IDX_W-1:0]       in_idx;
  logic [rnmt_pkg::VAL_W-1:0]       in_val;
  logic [rnmt_pkg::IDX_W-1:0]       elem_cnt;
  logic [rnmt_pkg::LEN_W-1:0]       cnt_inc;
  logic                             in_last;
  logic                             in_res;
  logic [rnmt_pkg::IDX_W-1:0]       rd_addr;

  assign accept  = s_axis_tvalid && s_axis_tready;
  assign in_op   = s_axis_tuser;
  assign in_idx  = s_axis_tdata[rnmt_pkg::IDX_W-1:0];
  assign in_val  = s_axis_tdata[rnmt_pkg::IDX_W +: rnmt_pkg::VAL_W];
  assign cnt_inc = rnmt_pkg::LEN_W'(elem_cnt) + 1'b1;
  assign in_last = (cnt_inc >= sum_len);
  assign in_res  = ((in_op == rnmt_pkg::OP_ELEM) && in_last) || (in_op == rnmt_pkg::OP_DELTA);
  assign rd_addr = (in_op == rnmt_pkg::OP_ELEM) ? elem_cnt : in_idx;

  always_ff @(posedge clk) begin
    if (rst) begin
      elem_cnt <= '0;
    end else if (accept && (in_op == rnmt_pkg::OP_ELEM)) begin
      elem_cnt <= in_last ? '0 : cnt_inc[rnmt_pkg::IDX_W-1:0];
    end
  end

  // weight ram
  logic                             wr_en;
  logic [rnmt_pkg::IDX_W-1:0]       wr_addr;
  logic [rnmt_pkg::VAL_W-1:0]       wr_data;
  logic [rnmt_pkg::VAL_W-1:0]       rd_data;

  rnmt_ram #(
    .WIDTH (rnmt_pkg::VAL_W),
    .DEPTH (rnmt_pkg::MAX_INPUTS)
  ) u_weight_ram (
    .clk   (clk),
    .we    (wr_en),
    .waddr (wr_addr),
    .wdata (wr_data),
    .raddr (rd_addr),
    .rdata (rd_data)
  );

  // stage 1: weight read data, write back, multiply
  logic                             s1_valid;
  logic [rnmt_pkg::OP_W-1:0]        s1_op;
  logic [rnmt_pkg::IDX_W-1:0]       s1_idx;
  logic [rnmt_pkg::VAL_W-1:0]       s1_val;
  logic                             s1_last;
  logic                             s1_res;
  logic                             fwd_hit;
  logic [rnmt_pkg::VAL_W-1:0]       fwd_data;
  logic signed [rnmt_pkg::VAL_W-1:0] weight;
  logic signed [rnmt_pkg::ACC_W:0]  sub_diff;
  logic signed [rnmt_pkg::VAL_W-1:0] mul_a;
  logic signed [rnmt_pkg::PROD_W-1:0] product;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
      s1_res   <= 1'b0;
      fwd_hit  <= 1'b0;
    end else begin
      s1_valid <= accept;
      s1_res   <= accept && in_res;
      // a write leaving stage 1 to the address being read is missed by the ram read
      fwd_hit  <= accept && wr_en && (wr_addr == rd_addr);
    end
  end

  always_ff @(posedge clk) begin
    s1_op    <= in_op;
    s1_idx   <= in_idx;
    s1_val   <= in_val;
    s1_last  <= in_last;
    fwd_data <= wr_data;
  end

  assign weight   = fwd_hit ? fwd_data : rd_data;
  assign sub_diff = (rnmt_pkg::ACC_W+1)'(weight) - (rnmt_pkg::ACC_W+1)'($signed(s1_val));
  assign wr_en    = s1_valid && ((s1_op == rnmt_pkg::OP_WRITE) || (s1_op == rnmt_pkg::OP_SUB));
  assign wr_addr  = s1_idx;
  assign wr_data  = (s1_op == rnmt_pkg::OP_WRITE) ? s1_val : sat32(sub_diff);
  assign mul_a    = (s1_op == rnmt_pkg::OP_BIAS) ? $signed({1'b0, learning_rate}) : weight;
  assign product  = rnmt_pkg::PROD_W'(mul_a) * rnmt_pkg::PROD_W'($signed(s1_val));

  // stage 2: scale product, accumulate
  logic                               s2_valid;
  logic [rnmt_pkg::OP_W-1:0]          s2_op;
  logic                               s2_last;
  logic                               s2_res;
  logic [rnmt_pkg::VAL_W-1:0]         s2_val;
  logic signed [rnmt_pkg::PROD_W-1:0] s2_prod;
  logic signed [rnmt_pkg::SHP_W-1:0]  prod_sh;
  logic signed [rnmt_pkg::ACC_W-1:0]  acc;
  logic signed [rnmt_pkg::ACC_W-1:0]  acc_sum;
  logic signed [rnmt_pkg::ACC_W-1:0]  s3_data_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      s2_valid <= 1'b0;
      s2_res   <= 1'b0;
    end else begin
      s2_valid <= s1_valid;
      s2_res   <= s1_res;
    end
  end

  always_ff @(posedge clk) begin
    s2_op   <= s1_op;
    s2_last <= s1_last;
    s2_val  <= s1_val;
    s2_prod <= product;
  end

  // floor shift to q32.16
  assign prod_sh = s2_prod[rnmt_pkg::PROD_W-1:rnmt_pkg::FRAC_W];
  assign acc_sum = acc + rnmt_pkg::ACC_W'(prod_sh);

  always_ff @(posedge clk) begin
    if (rst) begin
      acc <= '0;
    end else if (s2_valid && (s2_op == rnmt_pkg::OP_ELEM)) begin
      acc <= s2_last ? '0 : acc_sum;
    end
  end

  always_comb begin
    case (s2_op)
      rnmt_pkg::OP_ELEM: s3_data_next = acc_sum;
      rnmt_pkg::OP_BIAS: s3_data_next = rnmt_pkg::ACC_W'(prod_sh);
      default:           s3_data_next = rnmt_pkg::ACC_W'($signed(s2_val));
    endcase
  end

  // stage 3: bias add, saturate, relu, delta
  logic                               s3_valid;
  logic [rnmt_pkg::OP_W-1:0]          s3_op;
  logic                               s3_last;
  logic                               s3_res;
  logic signed [rnmt_pkg::ACC_W-1:0]  s3_data;
  logic signed [rnmt_pkg::VAL_W-1:0]  bias;
  logic signed [rnmt_pkg::VAL_W-1:0]  activation;
  logic signed [rnmt_pkg::ACC_W:0]    addend;
  logic signed [rnmt_pkg::ACC_W:0]    bias_sum;
  logic signed [rnmt_pkg::VAL_W-1:0]  sum_sat;
  logic signed [rnmt_pkg::VAL_W-1:0]  relu_out;
  rnmt_pkg::result_t                  push_data;
  logic                               push;

  always_ff @(posedge clk) begin
    if (rst) begin
      s3_valid <= 1'b0;
      s3_res   <= 1'b0;
    end else begin
      s3_valid <= s2_valid;
      s3_res   <= s2_res;
    end
  end

  always_ff @(posedge clk) begin
    s3_op   <= s2_op;
    s3_last <= s2_last;
    s3_data <= s3_data_next;
  end

  assign addend   = (s3_op == rnmt_pkg::OP_BIAS) ? -(rnmt_pkg::ACC_W+1)'(s3_data)
                                                 : (rnmt_pkg::ACC_W+1)'(s3_data);
  assign bias_sum = (rnmt_pkg::ACC_W+1)'(bias) + addend;
  assign sum_sat  = sat32(bias_sum);
  assign relu_out = sum_sat[rnmt_pkg::VAL_W-1] ? '0 : sum_sat;

  always_ff @(posedge clk) begin
    if (rst) begin
      bias       <= '0;
      activation <= '0;
    end else if (s3_valid) begin
      if ((s3_op == rnmt_pkg::OP_ELEM) && s3_last) begin
        activation <= relu_out;
      end
      if (s3_op == rnmt_pkg::OP_BIAS) begin
        bias <= sum_sat;
      end
    end
  end

  assign push = s3_valid && s3_res;

  always_comb begin
    if (s3_op == rnmt_pkg::OP_DELTA) begin
      push_data.kind  = rnmt_pkg::KIND_DELTA;
      push_data.value = (activation > 0) ? s3_data[rnmt_pkg::VAL_W-1:0] : '0;
    end else begin
      push_data.kind  = rnmt_pkg::KIND_ACT;
      push_data.value = relu_out;
    end
  end

  // result queue and input flow control
  rnmt_pkg::result_t              out_data;
  logic [rnmt_pkg::FIFO_AW:0]     fifo_level;
  logic [1:0]                     pending;
  logic [rnmt_pkg::FIFO_AW+1:0]   occupancy;

  rnmt_fifo u_result_fifo (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_data (push_data),
    .out_valid (m_axis_tvalid),
    .out_ready (m_axis_tready),
    .out_data  (out_data),
    .level     (fifo_level)
  );

  assign m_axis_tdata = out_data.value;
  assign m_axis_tuser = out_data.kind;

  assign pending   = 2'(s1_res) + 2'(s2_res) + 2'(s3_res);
  assign occupancy = (rnmt_pkg::FIFO_AW+2)'(fifo_level) + (rnmt_pkg::FIFO_AW+2)'(pending);
  // room for every result already in flight plus one more
  assign s_axis_tready = (occupancy < (rnmt_pkg::FIFO_AW+2)'(rnmt_pkg::FIFO_DEPTH));

endmodule

### tb/tb_relu_neuron_mac_train_unit.sv
// tb_relu_neuron_mac_train_unit: self-checking testbench for the relu neuron mac/train unit
`timescale 1ns / 1ps
module tb_relu_neuron_mac_train_unit;
  import rnmt_pkg::*;

  localparam int           CYCLE_LIMIT     = 500000;
  localparam int           ITEMS_PER_PHASE = 230;
  localparam int           SETTLE_CYCLES   = 12;
  localparam int           PHASES          = 8;
  localparam logic [OP_W-1:0] OP_SPARE     = 3'd5;  // first of the opcodes the block ignores
  localparam logic [OP_W-1:0] OP_SPARE_TOP = 3'd7;  // last of them

  typedef struct {
    logic [OP_W-1:0]  op;
    logic [IDX_W-1:0] idx;
    logic [VAL_W-1:0] val;
    bit               fixed;
    result_t          res;
  } stim_row_t;

  logic                 clk;
  logic                 rst;
  logic                 s_axis_tvalid;
  logic                 s_axis_tready;
  logic [IN_DATA_W-1:0] s_axis_tdata;   // weight_index, operand_value
  logic [OP_W-1:0]      s_axis_tuser;   // opcode
  logic                 m_axis_tvalid;
  logic                 m_axis_tready = 1'b0;
  logic [VAL_W-1:0]     m_axis_tdata;   // result_value
  logic                 m_axis_tuser;   // result_kind
  logic                 cfg_valid;
  logic                 cfg_ready;
  logic                 cfg_index;
  logic [RATE_W-1:0]    cfg_data;

  // neuron state as the block should hold it
  logic [VAL_W-1:0]  wts [MAX_INPUTS];
  logic [VAL_W-1:0]  bias_w;
  logic [VAL_W-1:0]  act_w;
  logic [VAL_W-1:0]  delta_w;
  longint            sum_acc;
  int unsigned       elem_cnt;
  logic [LEN_W-1:0]  act_len;
  logic [RATE_W-1:0] rate_w;

  result_t   outputs_due [$];
  result_t   due;
  stim_row_t stim_rows [$];
  int        err_count = 0;
  int        cycle_count = 0;
  int        send_idle_pct = 0;
  int        recv_stall_pct = 0;

  relu_neuron_mac_train_unit DUT (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("tb_relu_neuron_mac_train_unit: done, errors");
      $finish;
    end
  end

  task automatic note_mismatch(input string msg);
    if (err_count < 50) $display("mismatch at %0t: %s", $realtime, msg);
    err_count++;
  endtask

  function automatic logic [VAL_W-1:0] clamp_word(input longint x);
    if (x > 64'sd2147483647) return 32'h7fff_ffff;
    if (x < -64'sd2147483648) return 32'h8000_0000;
    return x[VAL_W-1:0];
  endfunction

  function automatic void neuron_clear();
    foreach (wts[i]) wts[i] = '0;
    bias_w   = '0;
    act_w    = '0;
    delta_w  = '0;
    sum_acc  = 0;
    elem_cnt = 0;
    act_len  = ACTIVE_RESET;
    rate_w   = RATE_RESET;
  endfunction

  // one accepted item; fires is set when the item produces a result
  task automatic neuron_step(input logic [OP_W-1:0] op, input logic [IDX_W-1:0] idx,
                             input logic [VAL_W-1:0] val, output bit fires, output result_t res);
    longint      v;
    longint      w;
    longint      a;
    longint      p;
    int unsigned n;
    int unsigned c;
    v     = longint'($signed(val));
    fires = 1'b0;
    res   = '0;
    case (op)
      OP_WRITE: wts[idx] = val;
      OP_SUB:   wts[idx] = clamp_word(longint'($signed(wts[idx])) - v);
      OP_ELEM: begin
        n = int'(act_len);
        if (n < 1) n = 1;
        if (n > MAX_INPUTS) n = MAX_INPUTS;
        c = elem_cnt;
        if (c >= MAX_INPUTS) c = MAX_INPUTS - 1;
        w = longint'($signed(wts[c]));
        sum_acc += (w * v) >>> FRAC_W;
        elem_cnt = c + 1;
        // a lowered length completes the sum as soon as the count reaches or passes it
        if (elem_cnt >= n) begin
          a = longint'($signed(clamp_word(longint'($signed(bias_w)) + sum_acc)));
          act_w     = (a < 0) ? '0 : a[VAL_W-1:0];
          sum_acc   = 0;
          elem_cnt  = 0;
          fires     = 1'b1;
          res.kind  = KIND_ACT;
          res.value = act_w;
        end
      end
      OP_DELTA: begin
        delta_w   = ($signed(act_w) > 0) ? val : '0;
        fires     = 1'b1;
        res.kind  = KIND_DELTA;
        res.value = delta_w;
      end
      OP_BIAS: begin
        p      = (longint'(rate_w) * v) >>> FRAC_W;
        bias_w = clamp_word(longint'($signed(bias_w)) - p);
      end
      default: ;
    endcase
  endtask

  function automatic void add_row(input logic [OP_W-1:0] op, input logic [IDX_W-1:0] idx,
                                  input logic [VAL_W-1:0] val, input bit fixed,
                                  input logic kind, input logic [VAL_W-1:0] value);
    stim_row_t row;
    row.op        = op;
    row.idx       = idx;
    row.val       = val;
    row.fixed     = fixed;
    row.res.kind  = kind;
    row.res.value = value;
    stim_rows.push_back(row);
  endfunction

  function automatic logic [VAL_W-1:0] draw_q16();
    int sel;
    int s;
    sel = $urandom_range(0, 99);
    if (sel < 50) begin
      s = int'($urandom_range(0, 524288)) - 262144;  // about +-4.0
      return s;
    end
    if (sel < 80) return $urandom;
    case ($urandom_range(0, 4))
      0:       return 32'h7fff_ffff;
      1:       return 32'h8000_0000;
      2:       return 32'h0000_0000;
      3:       return 32'hffff_ffff;
      default: return 32'h0001_0000;
    endcase
  endfunction

  // entered and left just after a falling edge
  task automatic send_item(input logic [OP_W-1:0] op, input logic [IDX_W-1:0] idx,
                           input logic [VAL_W-1:0] val, input bit fixed, input result_t typed);
    int      gap;
    bit      fires;
    result_t res;
    gap = 0;
    while ($urandom_range(0, 99) < send_idle_pct) gap++;
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= IN_DATA_W'({val, idx});
    s_axis_tuser  <= op;
    do @(posedge clk); while (!s_axis_tready);
    neuron_step(op, idx, val, fires, res);
    if (fires) outputs_due.push_back(fixed ? typed : res);
    @(negedge clk);
  endtask

  task automatic write_reg(input logic sel, input logic [RATE_W-1:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= sel;
    cfg_data  <= data;
    do @(posedge clk); while (!cfg_ready);
    if (sel == CFG_ACTIVE) act_len = data[LEN_W-1:0];
    else rate_w = data;
    @(negedge clk);
  endtask

  // drain every expected result, then let items without a result leave the pipeline
  task automatic settle();
    s_axis_tvalid <= 1'b0;
    while (outputs_due.size() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  always @(negedge clk) m_axis_tready <= ($urandom_range(0, 99) >= recv_stall_pct);

  always @(posedge clk) begin
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      if (outputs_due.size() == 0) begin
        note_mismatch($sformatf("unexpected result kind %0d value %h", m_axis_tuser, m_axis_tdata));
      end else begin
        due = outputs_due.pop_front();
        if (m_axis_tuser !== due.kind)
          note_mismatch($sformatf("kind %0d, want %0d", m_axis_tuser, due.kind));
        if (m_axis_tdata !== due.value)
          note_mismatch($sformatf("value %h, want %h", m_axis_tdata, due.value));
      end
    end
  end

  initial begin
    int               ph;
    int               k;
    int               r;
    logic [LEN_W-1:0] len;
    logic [RATE_W-1:0] rate;
    logic [OP_W-1:0]  op;
    rst           = 1'b1;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    s_axis_tuser  = '0;
    cfg_valid     = 1'b0;
    cfg_index     = 1'b0;
    cfg_data      = '0;
    neuron_clear();

    // directed rows run with two inputs per sum and the reset learning rate
    add_row(OP_DELTA, 6'd0,  32'h1234_5678, 1'b1, KIND_DELTA, 32'h0000_0000);
    add_row(OP_WRITE, 6'd0,  32'h7fff_ffff, 1'b0, KIND_ACT,   '0);
    add_row(OP_WRITE, 6'd1,  32'h7fff_ffff, 1'b0, KIND_ACT,   '0);
    add_row(OP_ELEM,  6'd0,  32'h7fff_ffff, 1'b0, KIND_ACT,   '0);
    add_row(OP_ELEM,  6'd63, 32'h7fff_ffff, 1'b1, KIND_ACT,   32'h7fff_ffff);
    add_row(OP_DELTA, 6'd63, 32'h8000_0000, 1'b1, KIND_DELTA, 32'h8000_0000);
    add_row(OP_WRITE, 6'd0,  32'h8000_0000, 1'b0, KIND_ACT,   '0);
    add_row(OP_WRITE, 6'd1,  32'h8000_0000, 1'b0, KIND_ACT,   '0);
    add_row(OP_ELEM,  6'd0,  32'h7fff_ffff, 1'b0, KIND_ACT,   '0);
    add_row(OP_ELEM,  6'd0,  32'h7fff_ffff, 1'b1, KIND_ACT,   32'h0000_0000);
    add_row(OP_DELTA, 6'd0,  32'h0000_0005, 1'b1, KIND_DELTA, 32'h0000_0000);
    add_row(OP_SUB,   6'd0,  32'h0000_0001, 1'b0, KIND_ACT,   '0);
    add_row(OP_SUB,   6'd1,  32'h8000_0000, 1'b0, KIND_ACT,   '0);
    add_row(OP_BIAS,  6'd0,  32'h8000_0000, 1'b0, KIND_ACT,   '0);
    add_row(OP_BIAS,  6'd0,  32'h7fff_ffff, 1'b0, KIND_ACT,   '0);
    add_row(OP_BIAS,  6'd0,  32'hffff_0000, 1'b0, KIND_ACT,   '0);
    add_row(OP_ELEM,  6'd0,  32'h0001_0000, 1'b0, KIND_ACT,   '0);
    add_row(OP_ELEM,  6'd0,  32'h7fff_ffff, 1'b0, KIND_ACT,   '0);
    add_row(OP_WRITE, 6'd0,  32'h0000_0001, 1'b0, KIND_ACT,   '0);
    add_row(OP_WRITE, 6'd1,  32'h0001_0000, 1'b0, KIND_ACT,   '0);
    add_row(OP_ELEM,  6'd0,  32'hffff_ffff, 1'b0, KIND_ACT,   '0);  // product rounds down
    add_row(OP_ELEM,  6'd0,  32'h0002_0000, 1'b0, KIND_ACT,   '0);
    add_row(OP_DELTA, 6'd0,  32'hffff_ffff, 1'b0, KIND_ACT,   '0);
    add_row(OP_SPARE, 6'd63, 32'hffff_ffff, 1'b0, KIND_ACT,   '0);
    add_row(OP_SPARE_TOP, 6'd63, 32'h8000_0000, 1'b0, KIND_ACT, '0);

    repeat (3) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);
    write_reg(CFG_ACTIVE, 31'd2);
    cfg_valid <= 1'b0;

    foreach (stim_rows[i])
      send_item(stim_rows[i].op, stim_rows[i].idx, stim_rows[i].val, stim_rows[i].fixed,
                stim_rows[i].res);

    for (ph = 0; ph < PHASES; ph++) begin
      settle();
      case (ph)
        0:       begin len = 7'd1;   rate = 31'd65536;      end
        1:       begin len = 7'd64;  rate = 31'd0;          end
        2:       begin len = 7'd0;   rate = 31'h7fff_ffff;  end
        3:       begin len = 7'd127; rate = 31'($urandom);  end
        4:       begin len = 7'($urandom_range(1, 64));  rate = 31'($urandom_range(0, 1048576)); end
        5:       begin len = 7'd3;   rate = 31'd65536;      end
        6:       begin len = 7'($urandom_range(0, 127)); rate = 31'($urandom); end
        default: begin len = 7'd5;   rate = 31'd1;          end
      endcase
      // upper bits of a length write carry noise
      write_reg(CFG_ACTIVE, {24'($urandom), len});
      write_reg(CFG_RATE, rate);
      cfg_valid <= 1'b0;
      case (ph % 4)
        0:       begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1:       begin send_idle_pct = 46; recv_stall_pct = 0;  end
        2:       begin send_idle_pct = 0;  recv_stall_pct = 46; end
        default: begin send_idle_pct = 23; recv_stall_pct = 23; end
      endcase
      if (ph == 0) begin
        for (k = 0; k < MAX_INPUTS; k++)
          send_item(OP_WRITE, IDX_W'(k), draw_q16(), 1'b0, '0);
      end
      for (k = 0; k < ITEMS_PER_PHASE; k++) begin
        r = $urandom_range(0, 99);
        if (r < 50)      op = OP_ELEM;
        else if (r < 62) op = OP_WRITE;
        else if (r < 70) op = OP_SUB;
        else if (r < 82) op = OP_DELTA;
        else if (r < 92) op = OP_BIAS;
        else             op = OP_SPARE + OP_W'($urandom_range(0, 2));
        send_item(op, IDX_W'($urandom_range(0, 63)), draw_q16(), 1'b0, '0);
      end
    end

    settle();
    if (err_count == 0) $display("tb_relu_neuron_mac_train_unit: done, clean");
    else $display("tb_relu_neuron_mac_train_unit: done, errors");
    $finish;
  end

endmodule
